/* rtl/deq_pkg.sv */
// Shared types and constants for the double-ended queue unit.
// Depends on nothing; imported by every module of the unit.
package deq_pkg;

    // ring store geometry
    localparam int DEPTH = 64;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // command opcodes as seen on the port
    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_LIST       = 3'd4;

    // result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // classified command kinds
    localparam logic [1:0] KIND_PUSH = 2'd0;
    localparam logic [1:0] KIND_POP  = 2'd1;
    localparam logic [1:0] KIND_LIST = 2'd2;

    typedef struct packed {
        logic [1:0]               kind;
        logic                     at_front;
        logic signed [DATA_W-1:0] value;
    } cmd_t;

endpackage

/* rtl/deq_front.sv */
// Front end of the double-ended queue unit: takes command transfers,
// classifies them and holds them in a two-entry queue. Depends on deq_pkg.
module deq_front
    import deq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    output logic                     cmd_ready,
    input  logic [2:0]               opcode,
    input  logic signed [DATA_W-1:0] value,
    output logic                     q_valid,
    input  logic                     q_ready,
    output cmd_t                     q_cmd
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       cmd_fire;
    logic       cmd_known;
    logic       push_q;
    logic       pop_q;
    cmd_t       cmd_in;

    // classify the incoming command
    always_comb
    begin
        cmd_in.value    = value;
        cmd_in.at_front = 1'b0;
        cmd_in.kind     = KIND_LIST;
        cmd_known       = 1'b1;
        case (opcode)
            OP_PUSH_FRONT:
            begin
                cmd_in.kind     = KIND_PUSH;
                cmd_in.at_front = 1'b1;
            end
            OP_PUSH_BACK:
            begin
                cmd_in.kind = KIND_PUSH;
            end
            OP_POP_FRONT:
            begin
                cmd_in.kind     = KIND_POP;
                cmd_in.at_front = 1'b1;
            end
            OP_POP_BACK:
            begin
                cmd_in.kind = KIND_POP;
            end
            OP_LIST:
            begin
                cmd_in.kind = KIND_LIST;
            end
            default:
            begin
                cmd_known = 1'b0;
            end
        endcase
    end

    // queue handshake; unused opcodes are taken and dropped
    assign cmd_ready = (fill_reg != 2'd2);
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign push_q    = cmd_fire && cmd_known;
    assign q_valid   = (fill_reg != 2'd0);
    assign pop_q     = q_valid && q_ready;
    assign q_cmd     = slot_reg[rd_ptr_reg];

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = push_q ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop_q ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push_q && !pop_q)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop_q && !push_q)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // queue slots
    always_ff @(posedge clk)
    begin
        if (push_q)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    // checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg != 2'd3)
        else $error("command queue overfilled");

    a_drop_unknown: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && !cmd_known && !pop_q) |=> (fill_reg == $past(fill_reg)))
        else $error("unused opcode entered the command queue");

    a_ptr_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers disagree with fill level");

endmodule

/* rtl/deq_back.sv */
// Back end of the double-ended queue unit: ring store, front/count state,
// list sequencer and result register. Depends on deq_pkg.
module deq_back
    import deq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_valid,
    output logic                     q_ready,
    input  cmd_t                     q_cmd,
    output logic                     res_valid,
    input  logic                     res_ready,
    output logic [1:0]               status,
    output logic signed [DATA_W-1:0] element,
    output logic                     last
);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_LST_RD  = 2'd1;
    localparam logic [1:0] ST_LST_OUT = 2'd2;

    logic [1:0]        state_reg, state_next;
    idx_t              front_reg, front_next;
    cnt_t              count_reg, count_next;
    idx_t              list_pos_reg, list_pos_next;
    cnt_t              list_left_reg, list_left_next;
    logic              res_valid_reg, res_valid_next;
    logic [1:0]        res_status_reg;
    logic [DATA_W-1:0] res_element_reg;
    logic              res_last_reg;

    logic [DATA_W-1:0] store_mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    logic              out_free;
    logic              q_fire;
    logic              full;
    logic              empty;
    idx_t              tail_idx;
    logic              res_load;
    logic [1:0]        load_status;
    logic [DATA_W-1:0] load_element;
    logic              load_last;
    logic              mem_we;
    idx_t              mem_waddr;
    logic              rd_en;

    // ring arithmetic modulo DEPTH
    function automatic idx_t ring_inc(input idx_t pos);
        ring_inc = (pos == IDX_W'(DEPTH - 1)) ? '0 : pos + 1'b1;
    endfunction

    function automatic idx_t ring_dec(input idx_t pos);
        ring_dec = (pos == '0) ? IDX_W'(DEPTH - 1) : pos - 1'b1;
    endfunction

    function automatic idx_t ring_add(input idx_t pos, input cnt_t cnt);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(pos) + (CNT_W + 1)'(cnt);
        if (sum >= (CNT_W + 1)'(DEPTH))
        begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        ring_add = sum[IDX_W-1:0];
    endfunction

    assign out_free = !res_valid_reg || res_ready;
    assign q_ready  = (state_reg == ST_IDLE) && out_free;
    assign q_fire   = q_valid && q_ready;
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign tail_idx = ring_add(front_reg, count_reg);

    // command execution and list sequencing
    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        count_next     = count_reg;
        list_pos_next  = list_pos_reg;
        list_left_next = list_left_reg;
        res_load       = 1'b0;
        load_status    = STAT_OK;
        load_element   = '0;
        load_last      = 1'b1;
        mem_we         = 1'b0;
        mem_waddr      = tail_idx;
        rd_en          = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_fire)
                begin
                    res_load = 1'b1;
                    case (q_cmd.kind)
                        KIND_PUSH:
                        begin
                            if (full)
                            begin
                                load_status = STAT_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                                if (q_cmd.at_front)
                                begin
                                    front_next = ring_dec(front_reg);
                                    mem_waddr  = ring_dec(front_reg);
                                end
                            end
                        end
                        KIND_POP:
                        begin
                            if (empty)
                            begin
                                load_status = STAT_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                                if (q_cmd.at_front)
                                begin
                                    front_next = ring_inc(front_reg);
                                end
                            end
                        end
                        KIND_LIST:
                        begin
                            if (empty)
                            begin
                                load_status = STAT_EMPTY;
                            end
                            else
                            begin
                                res_load       = 1'b0;
                                list_pos_next  = front_reg;
                                list_left_next = count_reg;
                                state_next     = ST_LST_RD;
                            end
                        end
                        default:
                        begin
                            res_load = 1'b0;
                        end
                    endcase
                end
            end
            ST_LST_RD:
            begin
                rd_en      = 1'b1;
                state_next = ST_LST_OUT;
            end
            ST_LST_OUT:
            begin
                if (out_free)
                begin
                    res_load     = 1'b1;
                    load_element = rd_data_reg;
                    load_last    = (list_left_reg == CNT_W'(1));
                    if (load_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        list_pos_next  = ring_inc(list_pos_reg);
                        list_left_next = list_left_reg - 1'b1;
                        state_next     = ST_LST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res_valid_next = res_load ? 1'b1 : (res_ready ? 1'b0 : res_valid_reg);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            list_pos_reg  <= '0;
            list_left_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            list_pos_reg  <= list_pos_next;
            list_left_reg <= list_left_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_status_reg  <= load_status;
            res_element_reg <= load_element;
            res_last_reg    <= load_last;
        end
    end

    // ring store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= q_cmd.value;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[list_pos_reg];
        end
    end

    assign res_valid = res_valid_reg;
    assign status    = res_status_reg;
    assign element   = res_element_reg;
    assign last      = res_last_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("element count above store depth");

    a_list_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (list_left_reg != '0 && !empty))
        else $error("list running over an empty sequence");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (q_fire && q_cmd.kind == KIND_PUSH && !full)
            |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("accepted push did not grow the sequence");

endmodule

/* rtl/double_ended_queue_unit.sv */
// Top level of the double-ended queue unit: command front end and execution back end.
// Depends on deq_pkg, deq_front and deq_back.
//
// Holds up to DEPTH (64) signed 32-bit elements in a ring store. Each command transfer
// on the cmd channel (opcode, value) yields result transfers on the res channel
// (status, element, last). Pushes and pops give one result each, are executed by the
// back end as it takes them and can sustain one command per cycle while results are
// taken and no list is running; a push into a full store is dropped with status full,
// a pop from an empty one reports empty. A list command yields one result per element
// from front to back, each through a registered read of the single store read port,
// then the result register, with last set on the final one; on an empty sequence it
// gives one empty result. Unused opcodes are taken and produce no result. A two-entry
// command queue lets new commands be taken while a list is running or a result is
// stalled. No clearing pass after reset: only written entries are ever read.
module double_ended_queue_unit
    import deq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    output logic                     cmd_ready,
    input  logic [2:0]               opcode,
    input  logic signed [DATA_W-1:0] value,
    output logic                     res_valid,
    input  logic                     res_ready,
    output logic [1:0]               status,
    output logic signed [DATA_W-1:0] element,
    output logic                     last
);

    logic q_valid;
    logic q_ready;
    cmd_t q_cmd;

    // command intake and classification
    deq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .opcode    (opcode),
        .value     (value),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_cmd     (q_cmd)
    );

    // execution and results
    deq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_cmd     (q_cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .status    (status),
        .element   (element),
        .last      (last)
    );

endmodule

/* verif/deq_checker.sv */
// Scoreboard for the double-ended queue unit: mirrors the deque and checks every result transfer.
// Depends on deq_pkg; instantiated beside u_dut by tb_double_ended_queue_unit.
module deq_checker
    import deq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    input  logic                     cmd_ready,
    input  logic [2:0]               opcode,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     res_valid,
    input  logic                     res_ready,
    input  logic [1:0]               status,
    input  logic signed [DATA_W-1:0] element,
    input  logic                     last,
    output int                       fail_count,
    output int                       pending
);

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] element;
        logic                     last;
    } deq_result_t;

    // mirror of the ring store and its pointers
    logic signed [DATA_W-1:0] mirror_ring [DEPTH];
    idx_t                     mirror_front;
    int                       mirror_count;

    // results still owed by the unit, oldest first
    deq_result_t awaited_results [$];

    function automatic idx_t ring_slot(input int pos);
        return idx_t'(pos % DEPTH);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge clk)
    begin : watch
        deq_result_t want;
        int          i;
        if (!rst_n)
        begin
            mirror_front = '0;
            mirror_count = 0;
            awaited_results.delete();
        end
        else
        begin
            // result side first, so a stray result is never masked by a new command
            if (res_valid && res_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    report_mismatch($sformatf(
                        "result with none awaited: status %0d element %0d last %0d",
                        status, element, last));
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (status !== want.status)
                        report_mismatch($sformatf("status %0d, wanted %0d", status, want.status));
                    if (element !== want.element)
                        report_mismatch($sformatf("element %0d, wanted %0d", element, want.element));
                    if (last !== want.last)
                        report_mismatch($sformatf("last %0d, wanted %0d", last, want.last));
                end
            end

            // predict the results of an accepted command
            if (cmd_valid && cmd_ready)
            begin
                case (opcode)
                    OP_PUSH_FRONT, OP_PUSH_BACK:
                    begin
                        if (mirror_count >= DEPTH)
                        begin
                            awaited_results.push_back('{STAT_FULL, '0, 1'b1});
                        end
                        else
                        begin
                            if (opcode == OP_PUSH_FRONT)
                            begin
                                mirror_front = ring_slot(int'(mirror_front) + DEPTH - 1);
                                mirror_ring[mirror_front] = value;
                            end
                            else
                            begin
                                mirror_ring[ring_slot(int'(mirror_front) + mirror_count)] = value;
                            end
                            mirror_count++;
                            awaited_results.push_back('{STAT_OK, '0, 1'b1});
                        end
                    end
                    OP_POP_FRONT, OP_POP_BACK:
                    begin
                        if (mirror_count == 0)
                        begin
                            awaited_results.push_back('{STAT_EMPTY, '0, 1'b1});
                        end
                        else
                        begin
                            if (opcode == OP_POP_FRONT)
                                mirror_front = ring_slot(int'(mirror_front) + 1);
                            mirror_count--;
                            awaited_results.push_back('{STAT_OK, '0, 1'b1});
                        end
                    end
                    OP_LIST:
                    begin
                        if (mirror_count == 0)
                        begin
                            awaited_results.push_back('{STAT_EMPTY, '0, 1'b1});
                        end
                        else
                        begin
                            for (i = 0; i < mirror_count; i++)
                            begin
                                want.status  = STAT_OK;
                                want.element = mirror_ring[ring_slot(int'(mirror_front) + i)];
                                want.last    = (i + 1 == mirror_count);
                                awaited_results.push_back(want);
                            end
                        end
                    end
                    default:
                    begin
                        // unused opcode: taken, no result, state untouched
                    end
                endcase
            end
        end
        pending = awaited_results.size();
    end

endmodule

/* verif/tb_double_ended_queue_unit.sv */
// Testbench top for the double-ended queue unit: clock, reset, command stimulus and verdict.
// Depends on deq_pkg, double_ended_queue_unit and deq_checker.
module tb_double_ended_queue_unit;
    import deq_pkg::*;

    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 300;

    logic                     clk;
    logic                     rst_n;
    logic                     cmd_valid;
    logic                     cmd_ready;
    logic [2:0]               opcode;
    logic signed [DATA_W-1:0] value;
    logic                     res_valid;
    logic                     res_ready;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] element;
    logic                     last;

    int fail_count;
    int pending;

    // idling controls for the sender and the receiver
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;

    double_ended_queue_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .opcode    (opcode),
        .value     (value),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .status    (status),
        .element   (element),
        .last      (last)
    );

    deq_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .opcode     (opcode),
        .value      (value),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .status     (status),
        .element    (element),
        .last       (last),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // receiver: random stalls, or a long hold-off counted here
    initial
    begin
        res_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                res_ready = 1'b0;
                hold_left--;
            end
            else
            begin
                res_ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // watchdog: ends the run when no transfer happens for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && cmd_ready) || (res_valid && res_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic signed [DATA_W-1:0] draw_element();
        case ($urandom_range(15))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // one command transfer; called and returns at a falling edge
    task automatic send_cmd(input logic [2:0] op, input logic signed [DATA_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid = 1'b0;
            @(negedge clk);
        end
        cmd_valid = 1'b1;
        opcode    = op;
        value     = val;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // sender pause until the unit has delivered everything owed
    task automatic wait_drained();
        cmd_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // random commands, push/pop mix drifting so the fill level wanders
    task automatic run_random(input int n);
        int         k;
        int         push_pct;
        int         r;
        logic [2:0] op;
        push_pct = 50;
        for (k = 0; k < n; k++)
        begin
            if (k % 6 == 0)
                push_pct = $urandom_range(80, 25);
            r = $urandom_range(99);
            if (r < 4)
                op = OP_LIST + 3'($urandom_range(3, 1));
            else if (r < 12)
                op = OP_LIST;
            else if ($urandom_range(99) < push_pct)
                op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
            else
                op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
            send_cmd(op, draw_element());
        end
    endtask

    // stimulus and verdict
    initial
    begin : stimulus
        int k;
        cmd_valid = 1'b0;
        opcode    = OP_PUSH_FRONT;
        value     = '0;
        rst_n     = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty cases, field extremes, every opcode
        send_cmd(OP_LIST, '0);
        send_cmd(OP_POP_FRONT, 32'sh7FFF_FFFF);
        send_cmd(OP_POP_BACK, 32'sh8000_0000);
        send_cmd(OP_PUSH_FRONT, 32'sh7FFF_FFFF);
        send_cmd(OP_PUSH_BACK, 32'sh8000_0000);
        send_cmd(OP_PUSH_FRONT, '0);
        send_cmd(OP_PUSH_BACK, '1);
        send_cmd(OP_PUSH_FRONT, 32'sh5555_5555);
        send_cmd(OP_PUSH_BACK, 32'shAAAA_AAAA);
        send_cmd(OP_LIST, '1);
        for (k = 1; k <= 3; k++)
            send_cmd(OP_LIST + 3'(k), $urandom);
        send_cmd(OP_POP_FRONT, '1);
        send_cmd(OP_POP_BACK, '1);
        send_cmd(OP_LIST, '0);
        send_cmd(OP_POP_FRONT, '0);
        send_cmd(OP_POP_BACK, '0);
        send_cmd(OP_POP_FRONT, '0);
        send_cmd(OP_LIST, '0);
        send_cmd(OP_POP_BACK, '0);
        send_cmd(OP_POP_BACK, '0);
        send_cmd(OP_LIST, '0);
        wait_drained();

        // fill to full behind a long receiver hold-off, overflow, list it all
        hold_left = HOLD_CYCLES;
        for (k = 0; k < DEPTH + 2; k++)
            send_cmd($urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT, draw_element());
        send_cmd(OP_LIST, '0);
        wait_drained();

        // random phases: no idling, sender idle, receiver stalling, both
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(18);
        wait_drained();
        send_idle_pct  = 52;
        recv_stall_pct = 0;
        run_random(18);
        wait_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 52;
        run_random(18);
        wait_drained();
        send_idle_pct  = 17;
        recv_stall_pct = 17;
        run_random(18);
        wait_drained();

        // let any stray result show up
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* double_ended_queue_unit.f */
rtl/deq_pkg.sv
rtl/deq_front.sv
rtl/deq_back.sv
rtl/double_ended_queue_unit.sv
verif/deq_checker.sv
verif/tb_double_ended_queue_unit.sv
